// ===== design/tsps_pkg.sv =====
package tsps_pkg;

   typedef enum logic [2:0] {
      FUNC_INSERT  = 3'd0,
      FUNC_REMOVE  = 3'd1,
      FUNC_READ    = 3'd2,
      FUNC_WRITE_X = 3'd3,
      FUNC_WRITE_Y = 3'd4,
      FUNC_WRITE_T = 3'd5
   } func_type;

   typedef enum logic [1:0] {
      STATUS_OK    = 2'd0,
      STATUS_RANGE = 2'd1,
      STATUS_FULL  = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_PREP,
      ST_DIV,
      ST_EXEC
   } state_type;

   localparam int unsigned DIV_STEPS = 7;

   typedef struct packed {
      logic       capture;
      logic       prep;
      logic       div_step;
      logic [2:0] div_shift;
      logic       exec;
   } cmd_type;

   typedef struct packed {
      logic need_div;
   } stat_type;

endpackage

// ===== design/tsps_control.sv =====
module tsps_control (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   output tsps_pkg::cmd_type   cmd,
   input  tsps_pkg::stat_type  stat
);

   tsps_pkg::state_type state_ff, state_in;
   logic [2:0]          step_ff, step_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= tsps_pkg::ST_IDLE;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      cmd      = '0;
      busy     = 1'b1;
      case (state_ff)
         tsps_pkg::ST_IDLE: begin
            busy = 1'b0;
            if (start) begin
               cmd.capture = 1'b1;
               state_in    = tsps_pkg::ST_PREP;
            end
         end
         tsps_pkg::ST_PREP: begin
            cmd.prep = 1'b1;
            if (stat.need_div) begin
               step_in  = 3'(tsps_pkg::DIV_STEPS - 1);
               state_in = tsps_pkg::ST_DIV;
            end else begin
               state_in = tsps_pkg::ST_EXEC;
            end
         end
         tsps_pkg::ST_DIV: begin
            cmd.div_step  = 1'b1;
            cmd.div_shift = step_ff;
            if (step_ff == '0) begin
               state_in = tsps_pkg::ST_EXEC;
            end else begin
               step_in = step_ff - 3'd1;
            end
         end
         tsps_pkg::ST_EXEC: begin
            cmd.exec = 1'b1;
            state_in = tsps_pkg::ST_IDLE;
         end
         default: begin
            state_in = tsps_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

// ===== design/tsps_datapath.sv =====
module tsps_datapath #(
   parameter int unsigned DEPTH = 64
) (
   input  logic                clock,
   input  logic                reset,
   input  tsps_pkg::cmd_type   cmd,
   output tsps_pkg::stat_type  stat,
   input  logic [2:0]          req_func,
   input  logic signed [6:0]   req_index,
   input  logic signed [15:0]  req_x_coord,
   input  logic signed [15:0]  req_y_coord,
   input  logic [31:0]         req_time_stamp,
   output logic                rsp_valid,
   output logic signed [15:0]  rsp_read_x,
   output logic signed [15:0]  rsp_read_y,
   output logic [31:0]         rsp_read_t,
   output logic [6:0]          rsp_count,
   output logic [1:0]          rsp_status
);

   localparam int unsigned CW = $clog2(DEPTH + 1);
   localparam int unsigned IW = $clog2(DEPTH);
   localparam int unsigned WW = CW + 7;

   logic [2:0]  func_ff;
   logic [6:0]  idx_ff;
   logic [15:0] xv_ff, yv_ff;
   logic [31:0] tv_ff;
   logic [6:0]  rem_ff, rem_in;
   logic [CW-1:0] fill_ff, fill_in;
   logic [DEPTH-1:0] gt_ff, gt_in;

   logic [15:0] x_ff [DEPTH];
   logic [15:0] y_ff [DEPTH];
   logic [31:0] t_ff [DEPTH];
   logic [15:0] x_in [DEPTH];
   logic [15:0] y_in [DEPTH];
   logic [31:0] t_in [DEPTH];

   logic        rsp_valid_ff;
   logic [15:0] rsp_x_ff, rsp_x_in, rsp_y_ff, rsp_y_in;
   logic [31:0] rsp_t_ff, rsp_t_in;
   logic [6:0]  rsp_count_ff;
   logic [1:0]  rsp_status_ff, rsp_status_in;

   logic          is_idx_op;
   logic [WW-1:0] divisor, rem_w, fill_w, pos_w;
   logic          pos_ok;
   logic [IW-1:0] pos;
   logic [DEPTH-1:0] hit, after;
   logic          acc;
   logic [WW-1:0] count_w;

   assign is_idx_op = (func_ff >= 3'(tsps_pkg::FUNC_REMOVE)) &&
                      (func_ff <= 3'(tsps_pkg::FUNC_WRITE_T));
   assign stat.need_div = is_idx_op && idx_ff[6] && (fill_ff != '0);

   assign fill_w  = WW'(fill_ff);
   assign rem_w   = WW'(rem_ff);
   assign divisor = fill_w << cmd.div_shift;

   always_comb begin
      rem_in = rem_ff;
      if (cmd.capture) begin
         rem_in = 7'(8'h80 - {1'b0, req_index});
      end else if (cmd.div_step && (rem_w >= divisor)) begin
         rem_in = 7'(rem_w - divisor);
      end
   end

   always_comb begin
      for (int k = 0; k < DEPTH; k++) begin
         gt_in[k] = (CW'(k) < fill_ff) && (tv_ff < t_ff[k]);
      end
   end

   always_comb begin
      if (idx_ff[6]) begin
         pos_w  = (rem_ff == '0) ? '0 : fill_w - rem_w;
         pos_ok = (fill_ff != '0);
      end else begin
         pos_w  = WW'(idx_ff[5:0]);
         pos_ok = (fill_ff != '0) && (pos_w < fill_w);
      end
      pos = pos_w[IW-1:0];
   end

   always_comb begin
      acc = 1'b0;
      for (int k = 0; k < DEPTH; k++) begin
         hit[k]   = gt_ff[k] || (CW'(k) == fill_ff);
         after[k] = acc;
         acc      = acc | hit[k];
      end
   end

   always_comb begin
      fill_in       = fill_ff;
      rsp_x_in      = '0;
      rsp_y_in      = '0;
      rsp_t_in      = '0;
      rsp_status_in = tsps_pkg::STATUS_OK;
      for (int k = 0; k < DEPTH; k++) begin
         x_in[k] = x_ff[k];
         y_in[k] = y_ff[k];
         t_in[k] = t_ff[k];
      end
      if (cmd.exec) begin
         if (func_ff == 3'(tsps_pkg::FUNC_INSERT)) begin
            if (fill_ff >= CW'(DEPTH)) begin
               rsp_status_in = tsps_pkg::STATUS_FULL;
            end else begin
               fill_in = fill_ff + 1'b1;
               for (int k = 0; k < DEPTH; k++) begin
                  if (hit[k] && !after[k]) begin
                     x_in[k] = xv_ff;
                     y_in[k] = yv_ff;
                     t_in[k] = tv_ff;
                  end else if (after[k] && k > 0) begin
                     x_in[k] = x_ff[k-1];
                     y_in[k] = y_ff[k-1];
                     t_in[k] = t_ff[k-1];
                  end
               end
            end
         end else if (is_idx_op) begin
            if (!pos_ok) begin
               rsp_status_in = tsps_pkg::STATUS_RANGE;
            end else begin
               case (func_ff)
                  3'(tsps_pkg::FUNC_REMOVE): begin
                     fill_in = fill_ff - 1'b1;
                     for (int k = 0; k < DEPTH - 1; k++) begin
                        if (IW'(k) >= pos) begin
                           x_in[k] = x_ff[k+1];
                           y_in[k] = y_ff[k+1];
                           t_in[k] = t_ff[k+1];
                        end
                     end
                  end
                  3'(tsps_pkg::FUNC_READ): begin
                     rsp_x_in = x_ff[pos];
                     rsp_y_in = y_ff[pos];
                     rsp_t_in = t_ff[pos];
                  end
                  3'(tsps_pkg::FUNC_WRITE_X): x_in[pos] = xv_ff;
                  3'(tsps_pkg::FUNC_WRITE_Y): y_in[pos] = yv_ff;
                  3'(tsps_pkg::FUNC_WRITE_T): t_in[pos] = tv_ff;
                  default: ;
               endcase
            end
         end
      end
   end

   assign count_w = WW'(fill_in);

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         fill_ff      <= fill_in;
         rsp_valid_ff <= cmd.exec;
      end
      if (cmd.capture) begin
         func_ff <= req_func;
         idx_ff  <= req_index;
         xv_ff   <= req_x_coord;
         yv_ff   <= req_y_coord;
         tv_ff   <= req_time_stamp;
      end
      if (cmd.prep) begin
         gt_ff <= gt_in;
      end
      rem_ff <= rem_in;
      for (int k = 0; k < DEPTH; k++) begin
         x_ff[k] <= x_in[k];
         y_ff[k] <= y_in[k];
         t_ff[k] <= t_in[k];
      end
      if (cmd.exec) begin
         rsp_x_ff      <= rsp_x_in;
         rsp_y_ff      <= rsp_y_in;
         rsp_t_ff      <= rsp_t_in;
         rsp_count_ff  <= count_w[6:0];
         rsp_status_ff <= rsp_status_in;
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_read_x = rsp_x_ff;
   assign rsp_read_y = rsp_y_ff;
   assign rsp_read_t = rsp_t_ff;
   assign rsp_count  = rsp_count_ff;
   assign rsp_status = rsp_status_ff;

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= CW'(DEPTH))
      else $error("fill count above depth");

   a_full_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_status_ff == tsps_pkg::STATUS_FULL) |-> fill_ff == CW'(DEPTH))
      else $error("full status while not full");

   a_insert_grows: assert property (@(posedge clock) disable iff (reset)
      cmd.exec && (func_ff == 3'(tsps_pkg::FUNC_INSERT)) && (fill_ff < CW'(DEPTH))
      |=> fill_ff == $past(fill_ff) + 1'b1)
      else $error("insert did not grow count");

   a_fill_quiet: assert property (@(posedge clock) disable iff (reset)
      !cmd.exec |=> $stable(fill_ff))
      else $error("count changed outside execute");

endmodule

// ===== design/time_sorted_point_store.sv =====
// rsp_valid is registered from the execute state, after a prepare state and,
// for an indexed request with a negative index on a nonempty store, a divide
// state whose wrap modulo the count takes a 7-step restoring remainder unit,
// one bit per cycle. Busy is low only in idle, so requests do not overlap.
// Reset (synchronous, active high) empties the store and clears rsp_valid;
// entry contents are not cleared. The receiver cannot stall rsp_valid.
module time_sorted_point_store #(
   parameter int unsigned DEPTH = 64
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [2:0]         req_func,
   input  logic signed [6:0]  req_index,
   input  logic signed [15:0] req_x_coord,
   input  logic signed [15:0] req_y_coord,
   input  logic [31:0]        req_time_stamp,
   output logic               rsp_valid,
   output logic signed [15:0] rsp_read_x,
   output logic signed [15:0] rsp_read_y,
   output logic [31:0]        rsp_read_t,
   output logic [6:0]         rsp_count,
   output logic [1:0]         rsp_status
);

   tsps_pkg::cmd_type  cmd;
   tsps_pkg::stat_type stat;

   tsps_control u_control (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .cmd   (cmd),
      .stat  (stat)
   );

   tsps_datapath #(.DEPTH(DEPTH)) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .stat           (stat),
      .req_func       (req_func),
      .req_index      (req_index),
      .req_x_coord    (req_x_coord),
      .req_y_coord    (req_y_coord),
      .req_time_stamp (req_time_stamp),
      .rsp_valid      (rsp_valid),
      .rsp_read_x     (rsp_read_x),
      .rsp_read_y     (rsp_read_y),
      .rsp_read_t     (rsp_read_t),
      .rsp_count      (rsp_count),
      .rsp_status     (rsp_status)
   );

endmodule

// ===== tb/testbench.sv =====
module testbench;

   localparam int NUM_ENTRIES = 64;
   localparam int STALL_LIMIT = 2000;

   typedef struct {
      logic signed [15:0] rd_x;
      logic signed [15:0] rd_y;
      logic [31:0]        rd_t;
      logic [6:0]         cnt;
      logic [1:0]         stat;
   } point_result_type;

   logic               clock = 0;
   logic               reset = 1;
   logic               start = 0;
   logic               busy;
   logic [2:0]         req_func = 0;
   logic signed [6:0]  req_index = 0;
   logic signed [15:0] req_x_coord = 0;
   logic signed [15:0] req_y_coord = 0;
   logic [31:0]        req_time_stamp = 0;
   logic               rsp_valid;
   logic signed [15:0] rsp_read_x;
   logic signed [15:0] rsp_read_y;
   logic [31:0]        rsp_read_t;
   logic [6:0]         rsp_count;
   logic [1:0]         rsp_status;

   logic signed [15:0] mdl_x [NUM_ENTRIES];
   logic signed [15:0] mdl_y [NUM_ENTRIES];
   logic [31:0]        mdl_t [NUM_ENTRIES];
   int                 mdl_fill = 0;
   point_result_type   expected_results [$];
   int                 errors = 0;
   int                 idle_pct = 0;
   int                 quiet_cycles = 0;

   time_sorted_point_store #(.DEPTH(NUM_ENTRIES)) uut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_func(req_func), .req_index(req_index), .req_x_coord(req_x_coord),
      .req_y_coord(req_y_coord), .req_time_stamp(req_time_stamp),
      .rsp_valid(rsp_valid), .rsp_read_x(rsp_read_x), .rsp_read_y(rsp_read_y),
      .rsp_read_t(rsp_read_t), .rsp_count(rsp_count), .rsp_status(rsp_status)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   function automatic bit resolve_position(logic [6:0] raw, output int pos);
      int mag;
      int r;
      if (mdl_fill == 0) return 0;
      if (raw[6]) begin
         mag = 128 - int'(raw);
         r = mag % mdl_fill;
         pos = (r == 0) ? 0 : mdl_fill - r;
      end else begin
         pos = int'(raw);
      end
      return pos < mdl_fill;
   endfunction

   function automatic point_result_type apply_point_op(logic [2:0] fn, logic [6:0] idx,
         logic signed [15:0] xv, logic signed [15:0] yv, logic [31:0] tv);
      point_result_type res;
      int pos;
      res = '{0, 0, 0, 0, tsps_pkg::STATUS_OK};
      if (fn == tsps_pkg::FUNC_INSERT) begin
         if (mdl_fill >= NUM_ENTRIES) begin
            res.stat = tsps_pkg::STATUS_FULL;
         end else begin
            pos = 0;
            while (pos < mdl_fill && !(tv < mdl_t[pos])) pos++;
            for (int k = mdl_fill; k > pos; k--) begin
               mdl_x[k] = mdl_x[k-1];
               mdl_y[k] = mdl_y[k-1];
               mdl_t[k] = mdl_t[k-1];
            end
            mdl_x[pos] = xv;
            mdl_y[pos] = yv;
            mdl_t[pos] = tv;
            mdl_fill++;
         end
      end else if (fn <= tsps_pkg::FUNC_WRITE_T) begin
         if (!resolve_position(idx, pos)) begin
            res.stat = tsps_pkg::STATUS_RANGE;
         end else begin
            case (fn)
               tsps_pkg::FUNC_REMOVE: begin
                  for (int k = pos; k + 1 < mdl_fill; k++) begin
                     mdl_x[k] = mdl_x[k+1];
                     mdl_y[k] = mdl_y[k+1];
                     mdl_t[k] = mdl_t[k+1];
                  end
                  mdl_fill--;
               end
               tsps_pkg::FUNC_READ: begin
                  res.rd_x = mdl_x[pos];
                  res.rd_y = mdl_y[pos];
                  res.rd_t = mdl_t[pos];
               end
               tsps_pkg::FUNC_WRITE_X: mdl_x[pos] = xv;
               tsps_pkg::FUNC_WRITE_Y: mdl_y[pos] = yv;
               default: mdl_t[pos] = tv;
            endcase
         end
      end
      res.cnt = 7'(mdl_fill);
      return res;
   endfunction

   task automatic send_request(logic [2:0] fn, logic [6:0] idx,
         logic signed [15:0] xv, logic signed [15:0] yv, logic [31:0] tv);
      point_result_type exp_item;
      while ($urandom_range(99) < idle_pct) begin
         start <= 0;
         @(posedge clock);
      end
      start <= 1;
      req_func <= fn;
      req_index <= idx;
      req_x_coord <= xv;
      req_y_coord <= yv;
      req_time_stamp <= tv;
      @(posedge clock);
      while (busy) @(posedge clock);
      exp_item = apply_point_op(fn, idx, xv, yv, tv);
      expected_results = {expected_results, exp_item};
   endtask

   function automatic logic [31:0] pick_stamp();
      case ($urandom_range(3))
         0: return $urandom_range(7);
         1: return 32'hFFFF_FFF8 + $urandom_range(7);
         default: return $urandom;
      endcase
   endfunction

   task automatic send_random(int n, int ins_bias);
      logic [2:0] fn;
      logic [6:0] idx;
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(99) < ins_bias) fn = tsps_pkg::FUNC_INSERT;
         else fn = 3'($urandom_range(7));
         if ($urandom_range(3) == 0) idx = 7'($urandom);
         else if (mdl_fill > 0 && $urandom_range(1) == 1)
            idx = 7'(-$urandom_range(mdl_fill, 1));
         else idx = 7'($urandom_range(mdl_fill > 0 ? mdl_fill - 1 : 0));
         send_request(fn, idx, 16'($urandom), 16'($urandom), pick_stamp());
      end
   endtask

   task automatic test_directed();
      send_request(tsps_pkg::FUNC_READ, 0, 0, 0, 0);
      send_request(tsps_pkg::FUNC_REMOVE, -7'sd1, 0, 0, 0);
      send_request(tsps_pkg::FUNC_WRITE_X, 7'sd63, 16'sh7FFF, 0, 0);
      send_request(tsps_pkg::FUNC_INSERT, 7'sd63, 16'sh7FFF, -16'sh8000, 32'hFFFF_FFFF);
      send_request(tsps_pkg::FUNC_INSERT, 0, -16'sh8000, 16'sh7FFF, 32'h0);
      send_request(tsps_pkg::FUNC_INSERT, 0, 16'sh1234, 16'sh4321, 32'h10);
      send_request(tsps_pkg::FUNC_INSERT, 0, 16'sh1111, 16'sh2222, 32'h10);
      send_request(tsps_pkg::FUNC_READ, 2, 0, 0, 0);
      send_request(tsps_pkg::FUNC_READ, 7'h40, 0, 0, 0);
      send_request(tsps_pkg::FUNC_READ, -7'sd1, 0, 0, 0);
      send_request(tsps_pkg::FUNC_READ, 4, 0, 0, 0);
      send_request(tsps_pkg::FUNC_WRITE_X, 1, -16'sh1, 0, 0);
      send_request(tsps_pkg::FUNC_WRITE_Y, -7'sd3, 0, -16'sh1, 0);
      send_request(tsps_pkg::FUNC_WRITE_T, 0, 0, 0, 32'hFFFF_FFFF);
      send_request(3'd6, 1, 0, 0, 0);
      send_request(3'd7, 1, 0, 0, 0);
      send_request(tsps_pkg::FUNC_REMOVE, 1, 0, 0, 0);
      send_request(tsps_pkg::FUNC_READ, 1, 0, 0, 0);
   endtask

   task automatic test_fill_full();
      while (mdl_fill < NUM_ENTRIES)
         send_request(tsps_pkg::FUNC_INSERT, 0, 16'($urandom), 16'($urandom),
            pick_stamp());
      send_request(tsps_pkg::FUNC_INSERT, 0, 1, 1, 1);
      send_request(tsps_pkg::FUNC_READ, 7'sd63, 0, 0, 0);
      send_request(tsps_pkg::FUNC_READ, 7'h40, 0, 0, 0);
      send_random(60, 20);
      while (mdl_fill > 0) send_request(tsps_pkg::FUNC_REMOVE, 7'($urandom), 0, 0, 0);
   endtask

   task automatic test_random_mix();
      idle_pct = 38;
      send_random(280, 45);
      idle_pct = 50;
      send_random(230, 35);
      idle_pct = 0;
      send_random(200, 40);
   endtask

   always @(posedge clock) begin
      point_result_type exp_res;
      if (!reset && rsp_valid) begin
         if (expected_results.size() == 0) begin
            $display("%0t: unexpected response count=%0d", $time, rsp_count);
            errors++;
         end else begin
            exp_res = expected_results.pop_front();
            if (rsp_read_x !== exp_res.rd_x || rsp_read_y !== exp_res.rd_y ||
                  rsp_read_t !== exp_res.rd_t || rsp_count !== exp_res.cnt ||
                  rsp_status !== exp_res.stat) begin
               $display("%0t: expected x=%0d y=%0d t=%0h cnt=%0d st=%0d", $time,
                  exp_res.rd_x, exp_res.rd_y, exp_res.rd_t, exp_res.cnt, exp_res.stat);
               $display("%0t: actual   x=%0d y=%0d t=%0h cnt=%0d st=%0d", $time,
                  rsp_read_x, rsp_read_y, rsp_read_t, rsp_count, rsp_status);
               errors++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || rsp_valid || (start && !busy)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("end of test: mismatches");
         $finish;
      end
   end

   initial begin
      repeat (7) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      test_directed();
      test_fill_full();
      test_random_mix();
      start <= 0;
      while (expected_results.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (errors == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end
endmodule
